[rtl/ihw_pkg.sv]
// Shared constants, types and helpers for the Intel HEX record writer.
// No dependencies; all files but ihw_ram refer to it by scoped names.

package ihw_pkg;

    localparam int RECORD_BYTES = 32;
    localparam int BUF_AW       = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CNT_W        = $clog2(RECORD_BYTES + 1);

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    localparam logic [6:0] CHAR_ZERO   = 7'h30;
    localparam logic [6:0] CHAR_A_BIAS = 7'h37;

    typedef struct packed {
        logic rec_start;
        logic rec_end;
        logic last;
    } t_flags;

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        logic [6:0] base;
        base = (nib < 4'd10) ? CHAR_ZERO : CHAR_A_BIAS;
        return 7'(base + {3'b000, nib});
    endfunction

endpackage

[rtl/ihw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ihw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ihw_out_stage.sv]
// Output register: converts one record byte to two ASCII hex digits and holds the beat.
// Depends on ihw_pkg (t_flags, hex_digit).

module ihw_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic [7:0]      i_byte,
    input  ihw_pkg::t_flags i_flags,
    output logic            o_ready,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [6:0]      o_hex_high_char,
    output logic [6:0]      o_hex_low_char,
    output logic            o_record_start,
    output logic            o_record_end,
    output logic            o_last
);

    logic            r_valid;
    logic [6:0]      r_hi;
    logic [6:0]      r_lo;
    ihw_pkg::t_flags r_flags;

    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
        if (o_ready && i_load) begin
            r_hi    <= ihw_pkg::hex_digit(i_byte[7:4]);
            r_lo    <= ihw_pkg::hex_digit(i_byte[3:0]);
            r_flags <= i_flags;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_hex_high_char = r_hi;
    assign o_hex_low_char  = r_lo;
    assign o_record_start  = r_flags.rec_start;
    assign o_record_end    = r_flags.rec_end;
    assign o_last          = r_flags.last;

endmodule

[rtl/intel_hex_record_writer.sv]
// Top level: record sequencer with shared checksum adder, byte buffer RAM, output stage.
// Depends on ihw_pkg, ihw_ram, ihw_out_stage.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall | i_op, i_byte_address, i_data_byte,
//           |           |                         | i_entry_address
//   out     | output    | o_out_valid/i_out_stall | o_hex_high_char, o_hex_low_char,
//           |           |                         | o_record_start, o_record_end, o_last
//
// A data byte that continues the record is written straight into the byte buffer.
// A record emits one record byte per cycle while the output does not stall: 5 + N bytes
// for N data bytes, one shared adder building the checksum. Finish emits up to 42 beats.
// Output stall freezes the sequencer; the input stalls while a record is emitted.
// Synchronous reset clears control state; the byte buffer is not cleared.

module intel_hex_record_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_byte_address,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_entry_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_hex_high_char,
    output logic [6:0]  o_hex_low_char,
    output logic        o_record_start,
    output logic        o_record_end,
    output logic        o_last
);

    localparam int AW = ihw_pkg::BUF_AW;
    localparam int CW = ihw_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_ADDRH,
        ST_ADDRL,
        ST_TYPE,
        ST_DATA,
        ST_CSUM
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic [15:0]     r_rec_addr, n_rec_addr;
    logic [31:0]     r_expected, n_expected;
    logic            r_await, n_await;
    logic            r_pend, n_pend;
    logic [7:0]      r_pend_byte, n_pend_byte;
    logic [31:0]     r_pend_addr, n_pend_addr;
    logic            r_end_next, n_end_next;
    logic [15:0]     r_entry, n_entry;
    logic            r_emit_eof, n_emit_eof;
    logic [15:0]     r_emit_addr, n_emit_addr;
    logic [CW-1:0]   r_emit_cnt, n_emit_cnt;
    logic [AW-1:0]   r_idx, n_idx;
    logic [7:0]      r_sum, n_sum;

    logic            in_acc;
    logic            brk;
    logic            out_ready;
    logic            emit_load;
    logic [7:0]      byte_sel;
    logic [7:0]      sum_base;
    ihw_pkg::t_flags flags;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_q;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign brk        = !r_await && ((i_byte_address != r_expected)
                        || (r_fill == CW'(ihw_pkg::RECORD_BYTES)));

    always_comb begin
        case (r_state)
            ST_COUNT: byte_sel = 8'(r_emit_cnt);
            ST_ADDRH: byte_sel = r_emit_addr[15:8];
            ST_ADDRL: byte_sel = r_emit_addr[7:0];
            ST_TYPE:  byte_sel = r_emit_eof ? ihw_pkg::REC_EOF : ihw_pkg::REC_DATA;
            ST_DATA:  byte_sel = ram_q;
            default:  byte_sel = 8'(8'd0 - r_sum);
        endcase
        sum_base        = (r_state == ST_COUNT) ? 8'd0 : r_sum;
        flags.rec_start = (r_state == ST_COUNT);
        flags.rec_end   = (r_state == ST_CSUM);
        flags.last      = (r_state == ST_CSUM) && !r_end_next;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_rec_addr  = r_rec_addr;
        n_expected  = r_expected;
        n_await     = r_await;
        n_pend      = r_pend;
        n_pend_byte = r_pend_byte;
        n_pend_addr = r_pend_addr;
        n_end_next  = r_end_next;
        n_entry     = r_entry;
        n_emit_eof  = r_emit_eof;
        n_emit_addr = r_emit_addr;
        n_emit_cnt  = r_emit_cnt;
        n_idx       = r_idx;
        n_sum       = r_sum;
        emit_load   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_fill[AW-1:0];
        ram_wdata   = i_data_byte;

        if (r_state != ST_IDLE && out_ready) begin
            emit_load = 1'b1;
            n_sum     = 8'(sum_base + byte_sel);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == ihw_pkg::OP_FINISH) begin
                        n_await    = 1'b1;
                        n_fill     = '0;
                        n_expected = '0;
                        n_rec_addr = '0;
                        n_entry    = i_entry_address;
                        n_state    = ST_COUNT;
                        if (r_fill != '0) begin
                            n_emit_eof  = 1'b0;
                            n_emit_addr = r_rec_addr;
                            n_emit_cnt  = r_fill;
                            n_end_next  = 1'b1;
                        end else begin
                            n_emit_eof  = 1'b1;
                            n_emit_addr = i_entry_address;
                            n_emit_cnt  = '0;
                            n_end_next  = 1'b0;
                        end
                    end else if (brk) begin
                        n_emit_eof  = 1'b0;
                        n_emit_addr = r_rec_addr;
                        n_emit_cnt  = r_fill;
                        n_end_next  = 1'b0;
                        n_pend      = 1'b1;
                        n_pend_byte = i_data_byte;
                        n_pend_addr = i_byte_address;
                        n_state     = ST_COUNT;
                    end else begin
                        ram_we     = 1'b1;
                        n_fill     = r_fill + CW'(1);
                        n_expected = i_byte_address + 32'd1;
                        if (r_await) begin
                            n_rec_addr = i_byte_address[15:0];
                            n_await    = 1'b0;
                        end
                    end
                end
            end
            ST_COUNT: if (out_ready) n_state = ST_ADDRH;
            ST_ADDRH: if (out_ready) n_state = ST_ADDRL;
            ST_ADDRL: if (out_ready) n_state = ST_TYPE;
            ST_TYPE: begin
                if (out_ready) begin
                    n_idx   = '0;
                    n_state = (r_emit_cnt == '0) ? ST_CSUM : ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_ready) begin
                    n_idx = r_idx + AW'(1);
                    if (CW'(r_idx) == r_emit_cnt - CW'(1)) begin
                        n_state = ST_CSUM;
                    end
                end
            end
            ST_CSUM: begin
                if (out_ready) begin
                    if (r_end_next) begin
                        n_emit_eof  = 1'b1;
                        n_emit_addr = r_entry;
                        n_emit_cnt  = '0;
                        n_end_next  = 1'b0;
                        n_state     = ST_COUNT;
                    end else begin
                        n_state = ST_IDLE;
                        if (r_pend) begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = r_pend_byte;
                            n_fill     = CW'(1);
                            n_rec_addr = r_pend_addr[15:0];
                            n_expected = r_pend_addr + 32'd1;
                            n_pend     = 1'b0;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_rec_addr <= '0;
            r_expected <= '0;
            r_await    <= 1'b1;
            r_pend     <= 1'b0;
            r_end_next <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_rec_addr <= n_rec_addr;
            r_expected <= n_expected;
            r_await    <= n_await;
            r_pend     <= n_pend;
            r_end_next <= n_end_next;
            r_idx      <= n_idx;
        end
        r_pend_byte <= n_pend_byte;
        r_pend_addr <= n_pend_addr;
        r_entry     <= n_entry;
        r_emit_eof  <= n_emit_eof;
        r_emit_addr <= n_emit_addr;
        r_emit_cnt  <= n_emit_cnt;
        r_sum       <= n_sum;
    end

    ihw_ram #(
        .WIDTH(8),
        .DEPTH(ihw_pkg::RECORD_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (ram_q)
    );

    ihw_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (emit_load),
        .i_byte          (byte_sel),
        .i_flags         (flags),
        .o_ready         (out_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hex_high_char (o_hex_high_char),
        .o_hex_low_char  (o_hex_low_char),
        .o_record_start  (o_record_start),
        .o_record_end    (o_record_end),
        .o_last          (o_last)
    );

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(ihw_pkg::RECORD_BYTES))
        else $error("buffer fill exceeds record size");

    a_await_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_fill == '0))
        else $error("bytes buffered before first byte");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_pend && !r_end_next))
        else $error("idle with unfinished work");

    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA) |-> (CW'(r_idx) < r_emit_cnt))
        else $error("data index beyond record count");

endmodule

[tb/intel_hex_record_writer_tb.sv]
// Self-checking testbench for intel_hex_record_writer: drives addressed bytes and finish
// beats, predicts every Intel HEX record beat and compares the output stream in order.
// Depends on ihw_pkg and the intel_hex_record_writer RTL.

module intel_hex_record_writer_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 64;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;

    typedef struct {
        logic [6:0] high_char;
        logic [6:0] low_char;
        logic       rec_start;
        logic       rec_end;
        logic       last;
    } t_hex_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = ihw_pkg::OP_DATA;
    logic [31:0] i_byte_address = '0;
    logic [7:0]  i_data_byte = '0;
    logic [15:0] i_entry_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [6:0]  o_hex_high_char;
    logic [6:0]  o_hex_low_char;
    logic        o_record_start;
    logic        o_record_end;
    logic        o_last;

    t_hex_beat   expected_hex_beats[$];
    logic [7:0]  model_buf[ihw_pkg::RECORD_BYTES];
    int          model_fill = 0;
    logic [31:0] model_rec_addr = '0;
    logic [31:0] model_next_addr = '0;
    logic        model_fresh = 1'b1;

    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    intel_hex_record_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_byte_address  (i_byte_address),
        .i_data_byte     (i_data_byte),
        .i_entry_address (i_entry_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hex_high_char (o_hex_high_char),
        .o_hex_low_char  (o_hex_low_char),
        .o_record_start  (o_record_start),
        .o_record_end    (o_record_end),
        .o_last          (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [6:0] nibble_char(input logic [3:0] nib);
        return (nib < 4'd10) ? CH_ZERO + 7'(nib) : CH_UPPER_A + 7'(nib) - 7'd10;
    endfunction

    function automatic void queue_record_byte(input logic [7:0] value, input logic rs,
                                              input logic re);
        t_hex_beat beat;
        beat.high_char = nibble_char(value[7:4]);
        beat.low_char  = nibble_char(value[3:0]);
        beat.rec_start = rs;
        beat.rec_end   = re;
        beat.last      = 1'b0;
        expected_hex_beats.push_back(beat);
    endfunction

    function automatic void queue_hex_record(input logic [7:0] rec_type,
                                             input logic [15:0] addr, input int count);
        logic [7:0] sum;
        sum = 8'(count) + addr[15:8] + addr[7:0] + rec_type;
        queue_record_byte(8'(count), 1'b1, 1'b0);
        queue_record_byte(addr[15:8], 1'b0, 1'b0);
        queue_record_byte(addr[7:0], 1'b0, 1'b0);
        queue_record_byte(rec_type, 1'b0, 1'b0);
        for (int k = 0; k < count; k++) begin
            sum = sum + model_buf[k];
            queue_record_byte(model_buf[k], 1'b0, 1'b0);
        end
        queue_record_byte(8'h00 - sum, 1'b0, 1'b1);
    endfunction

    function automatic void encode_hex_item(input logic op, input logic [31:0] addr,
                                            input logic [7:0] data, input logic [15:0] entry);
        int before_count;
        before_count = expected_hex_beats.size();
        if (op == ihw_pkg::OP_DATA) begin
            if (model_fresh) begin
                model_rec_addr  = addr;
                model_next_addr = addr;
                model_fill      = 0;
                model_fresh     = 1'b0;
            end
            if (model_next_addr != addr || model_fill >= ihw_pkg::RECORD_BYTES) begin
                if (model_fill > 0)
                    queue_hex_record(ihw_pkg::REC_DATA, model_rec_addr[15:0], model_fill);
                model_rec_addr  = addr;
                model_next_addr = addr;
                model_fill      = 0;
            end
            model_buf[model_fill] = data;
            model_fill++;
            model_next_addr = model_next_addr + 32'd1;
        end else begin
            if (model_fill > 0)
                queue_hex_record(ihw_pkg::REC_DATA, model_rec_addr[15:0], model_fill);
            queue_hex_record(ihw_pkg::REC_EOF, entry, 0);
            model_fill      = 0;
            model_rec_addr  = '0;
            model_next_addr = '0;
            model_fresh     = 1'b1;
        end
        if (expected_hex_beats.size() > before_count)
            expected_hex_beats[$].last = 1'b1;
    endfunction

    // predict on every accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            encode_hex_item(i_op, i_byte_address, i_data_byte, i_entry_address);
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_hex_beat exp_beat;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_hex_beats.size() == 0) begin
                $error("unexpected output beat: %s%s", o_hex_high_char, o_hex_low_char);
                error_count++;
            end else begin
                exp_beat = expected_hex_beats.pop_front();
                if (o_hex_high_char !== exp_beat.high_char) begin
                    $error("o_hex_high_char: expected %0h, got %0h",
                           exp_beat.high_char, o_hex_high_char);
                    error_count++;
                end
                if (o_hex_low_char !== exp_beat.low_char) begin
                    $error("o_hex_low_char: expected %0h, got %0h",
                           exp_beat.low_char, o_hex_low_char);
                    error_count++;
                end
                if (o_record_start !== exp_beat.rec_start) begin
                    $error("o_record_start: expected %0b, got %0b",
                           exp_beat.rec_start, o_record_start);
                    error_count++;
                end
                if (o_record_end !== exp_beat.rec_end) begin
                    $error("o_record_end: expected %0b, got %0b",
                           exp_beat.rec_end, o_record_end);
                    error_count++;
                end
                if (o_last !== exp_beat.last) begin
                    $error("o_last: expected %0b, got %0b", exp_beat.last, o_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("intel_hex_record_writer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // leave valid high on return; the next call decides whether to idle
    task automatic send_item(input logic op, input logic [31:0] addr, input logic [7:0] data,
                             input logic [15:0] entry);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_byte_address  <= addr;
        i_data_byte     <= data;
        i_entry_address <= entry;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_for_hex_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_hex_beats.size() != 0);
    endtask

    task automatic test_directed_cases();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_item(ihw_pkg::OP_FINISH, $urandom, 8'($urandom), 16'h0000);
        send_item(ihw_pkg::OP_DATA, 32'hFFFF_FFFE, 8'h00, 16'($urandom));
        send_item(ihw_pkg::OP_DATA, 32'hFFFF_FFFF, 8'hFF, 16'($urandom));
        send_item(ihw_pkg::OP_DATA, 32'h0000_0000, 8'hA5, 16'($urandom));
        send_item(ihw_pkg::OP_DATA, 32'h0001_2345, 8'h5A, 16'hFFFF);
        send_item(ihw_pkg::OP_DATA, 32'h0001_2346, 8'h3C, 16'h0000);
        send_item(ihw_pkg::OP_DATA, 32'h0001_2346, 8'hC3, 16'($urandom));
        send_item(ihw_pkg::OP_DATA, 32'h8000_0000, 8'h7E, 16'($urandom));
        send_item(ihw_pkg::OP_FINISH, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_item(ihw_pkg::OP_DATA, 32'h0000_0000, 8'h00, 16'($urandom));
        send_item(ihw_pkg::OP_FINISH, 32'h0000_0000, 8'h00, 16'h1234);
        wait_for_hex_drain();
    endtask

    task automatic test_random_records(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int          sent;
        int          run_len;
        int          pick;
        logic [31:0] cur_addr;
        sent = 0;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(ihw_pkg::OP_FINISH, $urandom, 8'($urandom), 16'($urandom));
                sent++;
            end else if (pick < 18) begin
                send_item(ihw_pkg::OP_DATA, $urandom, 8'($urandom), 16'($urandom));
                sent++;
            end else begin
                cur_addr = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(40)
                                                    : $urandom;
                run_len = ($urandom_range(4) == 0) ? $urandom_range(33, 70)
                                                   : $urandom_range(1, 32);
                for (int k = 0; k < run_len && sent < n_items; k++) begin
                    send_item(ihw_pkg::OP_DATA, cur_addr, 8'($urandom), 16'($urandom));
                    sent++;
                    pick = $urandom_range(99);
                    if (pick < 3)
                        cur_addr = cur_addr + $urandom_range(2, 3);
                    else if (pick >= 5)
                        cur_addr = cur_addr + 32'd1;
                end
            end
        end
        send_item(ihw_pkg::OP_FINISH, $urandom, 8'($urandom), 16'($urandom));
        wait_for_hex_drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_records(85, 0, 0);
        test_random_records(85, 47, 0);
        test_random_records(85, 0, 47);
        test_random_records(85, 33, 33);
        i_in_valid <= 1'b0;
        while (expected_hex_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_hex_beats.size() == 0)
            $display("intel_hex_record_writer: match");
        else
            $display("intel_hex_record_writer: mismatch");
        $finish;
    end

endmodule
